// ----- hw/rtl/spla_pkg.sv -----
package spla_pkg;

  // Fixed field widths of the request and result items
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;
  localparam int IN_USE_W = 9;

  // Default pool size
  localparam int SPLA_POOL_SLOTS = 256;

  // Operation codes
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_AL_TAIL,
    S_AL_WRAP,
    S_REL_HEAD,
    S_REL_TAIL,
    S_REL_UNLINK,
    S_REL_SPLICE,
    S_REL_LINK,
    S_REL_HEADP,
    S_FIN
  } state_t;

endpackage

// ----- hw/rtl/spla_if.sv -----
interface spla_req_if import spla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, func, slot, input ready);
  modport sink   (input valid, func, slot, output ready);
endinterface

interface spla_rsp_if import spla_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   given_slot;
  logic [SLOT_W-1:0]   resume_slot;
  logic [IN_USE_W-1:0] in_use;

  modport source (output valid, status, given_slot, resume_slot, in_use, input ready);
  modport sink   (input valid, status, given_slot, resume_slot, in_use, output ready);
endinterface

// ----- hw/rtl/slot_pool_linked_allocator_unit.sv -----
// Channel  Role    Payload                                     Accept
// -------  ------  ------------------------------------------  -----------------------
// req      sink    func (1), slot (8)                          req.valid & req.ready
// rsp      source  status (2), given_slot (8), resume_slot (8), rsp.valid & rsp.ready
//                  in_use (9)
//
// One item at a time. A full allocate or an empty or out-of-range release
// goes from S_IDLE straight to S_FIN; a plain allocate passes S_AL_TAIL, one
// that wraps onto the head S_AL_WRAP too, a head or tail release S_REL_HEAD or
// S_REL_TAIL, and a mid-ring release S_REL_UNLINK to S_REL_HEADP. The link rings
// live in two single-port-write memories with registered reads. After reset a
// clearing pass writes the ring in index order; req.ready stays low until it ends.
// The result sits in an output register, so req is taken again while rsp
// stalls; a second result waits in S_FIN until that register frees up.
module slot_pool_linked_allocator_unit import spla_pkg::*; #(
  parameter int POOL_SLOTS = SPLA_POOL_SLOTS
) (
  input  logic       clk,
  input  logic       rst,
  spla_req_if.sink   req,
  spla_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(POOL_SLOTS);
  localparam int CNT_W = $clog2(POOL_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(POOL_SLOTS);

  state_t state, state_next;

  // Ring pointers and occupancy
  logic [IDX_W-1:0] head_slot;
  logic [IDX_W-1:0] tail_slot;
  logic [CNT_W-1:0] used_count;
  logic [IDX_W-1:0] clr_idx;

  // Item in flight and its pending result
  logic [IDX_W-1:0]    item_slot;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_given;
  logic [SLOT_W-1:0]   res_resume;

  // Link memories
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] next_rd, prev_rd;
  logic             next_we, prev_we;
  logic [IDX_W-1:0] next_waddr, prev_waddr;
  logic [IDX_W-1:0] next_wdata, prev_wdata;

  // Output register
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_given;
  logic [SLOT_W-1:0]   out_resume;
  logic [IN_USE_W-1:0] out_in_use;

  logic             in_fire;
  logic             out_load;
  logic             out_free;
  logic [IDX_W-1:0] in_idx;
  logic             in_range;
  logic             is_full;
  logic             is_empty;
  logic             hit_head;
  logic             hit_tail;
  logic             wraps;
  logic [IDX_W-1:0] clr_inc;
  logic [IDX_W-1:0] clr_dec;

  spla_link_ram #(.DEPTH(POOL_SLOTS), .WIDTH(IDX_W)) u_next_ram (
    .clk  (clk),
    .we   (next_we),
    .waddr(next_waddr),
    .wdata(next_wdata),
    .raddr(rd_addr),
    .rdata(next_rd)
  );

  spla_link_ram #(.DEPTH(POOL_SLOTS), .WIDTH(IDX_W)) u_prev_ram (
    .clk  (clk),
    .we   (prev_we),
    .waddr(prev_waddr),
    .wdata(prev_wdata),
    .raddr(rd_addr),
    .rdata(prev_rd)
  );

  // Decode the incoming item against the ring pointers
  assign in_fire  = req.valid && req.ready;
  assign in_idx   = IDX_W'(req.slot);
  assign in_range = (32'(req.slot) < 32'(POOL_SLOTS));
  assign is_full  = (used_count >= FULL_CNT);
  assign is_empty = (used_count == '0);
  assign hit_head = (in_idx == head_slot);
  assign hit_tail = (in_idx == tail_slot);
  // Advanced tail runs onto the head while slots are in use
  assign wraps    = (used_count != '0) && (next_rd == head_slot);
  assign out_free = !out_valid || rsp.ready;

  // Clearing pass: neighbors of clr_idx in index order
  assign clr_inc = (clr_idx == LAST_IDX) ? '0 : clr_idx + 1'b1;
  assign clr_dec = (clr_idx == '0) ? LAST_IDX : clr_idx - 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (req.func == FUNC_ALLOC) begin
            state_next = is_full ? S_FIN : S_AL_TAIL;
          end else if (is_empty || !in_range) begin
            state_next = S_FIN;
          end else if (hit_head) begin
            state_next = S_REL_HEAD;
          end else if (hit_tail) begin
            state_next = S_REL_TAIL;
          end else begin
            state_next = S_REL_UNLINK;
          end
        end
      end
      S_AL_TAIL:    state_next = wraps ? S_AL_WRAP : S_FIN;
      S_AL_WRAP:    state_next = S_FIN;
      S_REL_HEAD:   state_next = S_FIN;
      S_REL_TAIL:   state_next = S_FIN;
      S_REL_UNLINK: state_next = S_REL_SPLICE;
      S_REL_SPLICE: state_next = S_REL_LINK;
      S_REL_LINK:   state_next = S_REL_HEADP;
      S_REL_HEADP:  state_next = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready  = 1'b0;
    out_load   = 1'b0;
    rd_addr    = item_slot;
    next_we    = 1'b0;
    next_waddr = clr_idx;
    next_wdata = clr_inc;
    prev_we    = 1'b0;
    prev_waddr = clr_idx;
    prev_wdata = clr_dec;
    unique case (state)
      S_CLEAR: begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      S_IDLE: begin
        // Fetch the links this item will need next cycle
        req.ready = 1'b1;
        rd_addr   = (req.func == FUNC_ALLOC) ? tail_slot : in_idx;
      end
      S_AL_TAIL: begin
        rd_addr = head_slot;
      end
      S_REL_UNLINK: begin
        // Bridge pred and succ over the released slot
        next_we    = 1'b1;
        next_waddr = prev_rd;
        next_wdata = next_rd;
        prev_we    = 1'b1;
        prev_waddr = next_rd;
        prev_wdata = prev_rd;
      end
      S_REL_SPLICE: begin
        next_we    = 1'b1;
        next_waddr = item_slot;
        next_wdata = head_slot;
        rd_addr    = head_slot;
      end
      S_REL_LINK: begin
        // prev_rd is the slot now standing just before the head
        prev_we    = 1'b1;
        prev_waddr = item_slot;
        prev_wdata = prev_rd;
        next_we    = 1'b1;
        next_waddr = prev_rd;
        next_wdata = item_slot;
      end
      S_REL_HEADP: begin
        prev_we    = 1'b1;
        prev_waddr = head_slot;
        prev_wdata = item_slot;
      end
      S_FIN: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      head_slot  <= '0;
      tail_slot  <= LAST_IDX;
      used_count <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_inc;
      end
      if (state == S_IDLE && in_fire && req.func == FUNC_RELEASE &&
          !is_empty && in_range) begin
        used_count <= used_count - 1'b1;
      end
      if (state == S_AL_TAIL) begin
        tail_slot <= next_rd;
        if (!wraps) begin
          used_count <= used_count + 1'b1;
        end
      end
      if (state == S_AL_WRAP || state == S_REL_HEAD) begin
        head_slot <= next_rd;
      end
      if (state == S_REL_TAIL) begin
        tail_slot <= prev_rd;
      end
    end
  end

  // Result fields of the item in flight
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        item_slot  <= in_idx;
        res_given  <= '0;
        res_resume <= '0;
        if (req.func == FUNC_ALLOC) begin
          res_status <= is_full ? STATUS_FULL : STATUS_DONE;
        end else if (is_empty) begin
          res_status <= STATUS_EMPTY;
        end else begin
          res_status <= STATUS_DONE;
          // Head release resumes at itself; out-of-range echoes the slot
          if (!in_range || hit_head) begin
            res_resume <= req.slot;
          end
        end
      end
      S_AL_TAIL:    res_given  <= SLOT_W'(next_rd);
      S_REL_TAIL:   res_resume <= SLOT_W'(prev_rd);
      S_REL_UNLINK: res_resume <= SLOT_W'(prev_rd);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_given  <= res_given;
      out_resume <= res_resume;
      out_in_use <= IN_USE_W'(used_count);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.given_slot  = out_given;
  assign rsp.resume_slot = out_resume;
  assign rsp.in_use      = out_in_use;

endmodule

// ----- hw/rtl/spla_link_ram.sv -----
module spla_link_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench import spla_pkg::*;;

  localparam int POOL = SPLA_POOL_SLOTS;
  localparam int ITEM_TARGET = 1200;
  localparam int MAX_REPORTS = 10;

  // One result item as the rsp channel carries it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   given;
    logic [SLOT_W-1:0]   resume;
    logic [IN_USE_W-1:0] in_use;
  } pool_result_t;

  // Row of the directed table; typed rows carry their own expectation
  typedef struct {
    logic         func;
    logic [SLOT_W-1:0] slot;
    bit           typed;
    pool_result_t result;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  spla_req_if req_ch ();
  spla_rsp_if rsp_ch ();

  slot_pool_linked_allocator_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the slot ring, advanced once per accepted request item
  logic [SLOT_W-1:0]   link_fwd [POOL];
  logic [SLOT_W-1:0]   link_back [POOL];
  logic [SLOT_W-1:0]   ring_first;
  logic [SLOT_W-1:0]   ring_last;
  logic [IN_USE_W-1:0] held_count;

  pool_result_t awaited_results [$];
  pool_result_t last_outcome;
  int           fault_count = 0;
  int           items_sent = 0;
  int           burst_left = 0;

  // Receiver stall pattern state
  int stall_phase = 0;
  int stall_mode = 0;

  // Directed part: empty releases with both slot extremes, in-order allocates
  // from a fresh ring, then a mid-run, a tail and a head release and refills.
  plan_row_t directed_plan [13] = '{
    '{FUNC_RELEASE, 8'd0,   1'b1, '{STATUS_EMPTY, 8'd0, 8'd0, 9'd0}},
    '{FUNC_RELEASE, 8'd255, 1'b1, '{STATUS_EMPTY, 8'd0, 8'd0, 9'd0}},
    '{FUNC_ALLOC,   8'd255, 1'b1, '{STATUS_DONE,  8'd0, 8'd0, 9'd1}},
    '{FUNC_ALLOC,   8'd0,   1'b1, '{STATUS_DONE,  8'd1, 8'd0, 9'd2}},
    '{FUNC_ALLOC,   8'd170, 1'b1, '{STATUS_DONE,  8'd2, 8'd0, 9'd3}},
    '{FUNC_ALLOC,   8'd85,  1'b1, '{STATUS_DONE,  8'd3, 8'd0, 9'd4}},
    '{FUNC_RELEASE, 8'd2,   1'b0, '0},
    '{FUNC_RELEASE, 8'd3,   1'b0, '0},
    '{FUNC_RELEASE, 8'd0,   1'b0, '0},
    '{FUNC_ALLOC,   8'd0,   1'b0, '0},
    '{FUNC_ALLOC,   8'd255, 1'b0, '0},
    '{FUNC_RELEASE, 8'd1,   1'b0, '0},
    '{FUNC_ALLOC,   8'd0,   1'b0, '0}
  };

  // Rebuild the ring in index order with nothing in use
  function automatic void pool_reset();
    for (int i = 0; i < POOL; i++) begin
      link_fwd[i]  = SLOT_W'((i + 1) % POOL);
      link_back[i] = SLOT_W'((i + POOL - 1) % POOL);
    end
    ring_first = '0;
    ring_last  = SLOT_W'(POOL - 1);
    held_count = '0;
  endfunction

  // Apply one request item to the shadow ring and return its result item
  function automatic pool_result_t pool_apply(logic func, logic [SLOT_W-1:0] slot);
    pool_result_t r;
    logic [SLOT_W-1:0] pred;
    logic [SLOT_W-1:0] succ;
    logic [SLOT_W-1:0] ahead;
    r = '0;
    r.status = STATUS_DONE;
    if (func == FUNC_ALLOC) begin
      if (held_count >= POOL) begin
        r.status = STATUS_FULL;
      end else begin
        r.given   = link_fwd[ring_last];
        ring_last = r.given;
        // tail ran onto head: push head forward, count stays
        if (held_count > 0 && ring_last == ring_first) begin
          ring_first = link_fwd[ring_first];
        end else begin
          held_count = held_count + 1'b1;
        end
      end
    end else if (held_count == 0) begin
      r.status = STATUS_EMPTY;
    end else if (int'(slot) >= POOL) begin
      r.resume = slot;
    end else begin
      held_count = held_count - 1'b1;
      if (slot == ring_first) begin
        ring_first = link_fwd[slot];
        r.resume   = slot;
      end else if (slot == ring_last) begin
        ring_last = link_back[slot];
        r.resume  = ring_last;
      end else begin
        // unlink from the used run, then splice in just ahead of head
        pred = link_back[slot];
        succ = link_fwd[slot];
        link_fwd[pred]  = succ;
        link_back[succ] = pred;
        link_fwd[slot]  = ring_first;
        link_back[slot] = link_back[ring_first];
        ahead = link_back[ring_first];
        link_fwd[ahead] = slot;
        link_back[ring_first] = slot;
        r.resume = pred;
      end
    end
    r.in_use = held_count;
    return r;
  endfunction

  // Walk the used run from head to a random slot in it
  function automatic logic [SLOT_W-1:0] pick_held();
    int k;
    logic [SLOT_W-1:0] p;
    k = $urandom_range(0, int'(held_count) - 1);
    p = ring_first;
    repeat (k) p = link_fwd[p];
    return p;
  endfunction

  // Walk the free run from the slot after tail to a random slot in it
  function automatic logic [SLOT_W-1:0] pick_free();
    int k;
    logic [SLOT_W-1:0] p;
    k = $urandom_range(0, POOL - 1 - int'(held_count));
    p = link_fwd[ring_last];
    repeat (k) p = link_fwd[p];
    return p;
  endfunction

  // Offer one request item in bursts with random gaps; on acceptance, advance
  // the shadow ring and queue the expected result (typed or predicted).
  task automatic send_item(input logic func, input logic [SLOT_W-1:0] slot,
                           input bit typed = 1'b0, input pool_result_t typed_result = '0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.func  <= func;
    req_ch.slot  <= slot;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    last_outcome = pool_apply(func, slot);
    awaited_results.push_back(typed ? typed_result : last_outcome);
    items_sent++;
  endtask

  // Drop valid and hold off until every queued result has come back
  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  initial begin : stimulus
    int seg_len;
    int alloc_pct;
    int wrap_hits;
    int guard;
    logic [IN_USE_W-1:0] count_prior;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func  = FUNC_ALLOC;
    req_ch.slot  = '0;
    pool_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table; ready stays low through the clearing pass, so the
    // first item simply waits for it
    foreach (directed_plan[i]) begin
      send_item(directed_plan[i].func, directed_plan[i].slot,
                directed_plan[i].typed, directed_plan[i].result);
    end
    hold_until_drained();

    // Fill the pool, then knock on it a few times while full
    while (held_count < POOL) send_item(FUNC_ALLOC, SLOT_W'($urandom));
    repeat (4) send_item(FUNC_ALLOC, SLOT_W'($urandom));

    // Drain with releases of used slots, then release into an empty pool
    while (held_count > 0) send_item(FUNC_RELEASE, pick_held());
    repeat (3) send_item(FUNC_RELEASE, SLOT_W'($urandom));
    hold_until_drained();

    // Release a slot that is not in use so the count falls behind the ring,
    // then allocate until the tail runs onto the head a few times
    repeat (3) send_item(FUNC_ALLOC, SLOT_W'($urandom));
    send_item(FUNC_RELEASE, pick_free());
    wrap_hits = 0;
    guard = 0;
    while (wrap_hits < 3 && guard < 300) begin
      count_prior = held_count;
      send_item(FUNC_ALLOC, SLOT_W'($urandom));
      if (last_outcome.status == STATUS_DONE && last_outcome.in_use == count_prior)
        wrap_hits++;
      guard++;
    end

    // Random segments: releases mostly of used slots, some noise releases
    // of arbitrary slots, allocate share varied per segment
    while (items_sent < ITEM_TARGET) begin
      seg_len = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0: alloc_pct = 15;
        1: alloc_pct = 50;
        default: alloc_pct = 85;
      endcase
      repeat (seg_len) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          send_item(FUNC_ALLOC, SLOT_W'($urandom));
        end else if (held_count == 0 || $urandom_range(0, 99) < 8) begin
          send_item(FUNC_RELEASE, SLOT_W'($urandom_range(0, POOL - 1)));
        end else begin
          send_item(FUNC_RELEASE, pick_held());
        end
      end
      if ($urandom_range(0, 3) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Receiver: switch among always-ready, coin-flip and long-stall modes
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_phase <= $urandom_range(30, 200);
      stall_mode  <= $urandom_range(0, 2);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= 1'($urandom_range(0, 1));
      default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  initial rsp_ch.ready = 1'b0;

  // Compare each accepted result item with the oldest expectation
  always @(posedge clk) begin : rsp_check
    pool_result_t seen;
    pool_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen = '{rsp_ch.status, rsp_ch.given_slot, rsp_ch.resume_slot, rsp_ch.in_use};
      if (awaited_results.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("testbench: unexpected result status=%0d given=%0d resume=%0d in_use=%0d",
                   seen.status, seen.given, seen.resume, seen.in_use);
      end else begin
        want = awaited_results.pop_front();
        if (seen.status !== want.status || seen.given !== want.given ||
            seen.resume !== want.resume || seen.in_use !== want.in_use) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("testbench: mismatch exp status=%0d given=%0d resume=%0d in_use=%0d %s",
                     want.status, want.given, want.resume, want.in_use,
                     $sformatf("got status=%0d given=%0d resume=%0d in_use=%0d",
                               seen.status, seen.given, seen.resume, seen.in_use));
        end
      end
    end
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
